// ===== hw/rtl/mfp_pkg.sv =====
// ----------------------------------------------------------------------------
// mfp_pkg
// Shared types, constants and the CRC-8 step function of the frame packer.
// ----------------------------------------------------------------------------
package mfp_pkg;

    localparam int MAX_PAYLOAD_DEF = 64;
    localparam int Q_DEPTH         = 4;
    localparam int PADDR_W         = 3;

    localparam logic REG_DEV_ADDR = 1'b0;
    localparam logic REG_CRC_POLY = 1'b1;

    typedef enum logic {
        K_START = 1'b0,
        K_DATA  = 1'b1
    } t_kind;

    // b0..b2 carry address, command and length of a start; b0 the byte of a data entry
    typedef struct packed {
        t_kind      kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       last;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    function automatic logic [7:0] crc8_absorb(input logic [7:0] crc,
                                               input logic [7:0] din,
                                               input logic [7:0] poly);
        logic [7:0] r;
        r = crc ^ din;
        for (int i = 0; i < 8; i++) begin
            if (r[7]) begin
                r = {r[6:0], 1'b0} ^ poly;
            end else begin
                r = {r[6:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/mfp_in_if.sv =====
// ----------------------------------------------------------------------------
// mfp_in_if
// Input channel of the frame packer: start and payload items.
// ----------------------------------------------------------------------------
interface mfp_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] command;
    logic [6:0] length;
    logic [7:0] data_byte;

    modport source (output valid, func, command, length, data_byte, input ready);
    modport sink   (input valid, func, command, length, data_byte, output ready);
endinterface

// ===== hw/rtl/mfp_out_if.sv =====
// ----------------------------------------------------------------------------
// mfp_out_if
// Output channel of the frame packer: one frame byte per beat.
// ----------------------------------------------------------------------------
interface mfp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;

    modport source (output valid, out_byte, frame_end, input ready);
    modport sink   (input valid, out_byte, frame_end, output ready);
endinterface

// ===== hw/rtl/mfp_front.sv =====
// ----------------------------------------------------------------------------
// mfp_front
// Accepts items, tracks frame position and queues start and data entries.
// ----------------------------------------------------------------------------
module mfp_front #(
    parameter int MAX_PAYLOAD = mfp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    mfp_in_if.sink              i_in,
    input  logic [7:0]          i_dev_addr,
    input  logic                i_q_full,
    output logic                o_push,
    output mfp_pkg::t_entry     o_entry
);

    logic       r_in_frame;
    logic [6:0] r_bytes_left;
    logic       n_in_frame;
    logic [6:0] n_bytes_left;
    logic       w_accept;
    logic [6:0] w_len;

    assign i_in.ready = !i_q_full;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        if ({1'b0, i_in.length} > 8'(MAX_PAYLOAD)) begin
            w_len = 7'(MAX_PAYLOAD);
        end else begin
            w_len = i_in.length;
        end
    end

    always_comb begin
        n_in_frame   = r_in_frame;
        n_bytes_left = r_bytes_left;
        o_push       = 1'b0;
        o_entry.kind = mfp_pkg::K_START;
        o_entry.b0   = i_dev_addr;
        o_entry.b1   = i_in.command;
        o_entry.b2   = {1'b0, w_len};
        o_entry.last = (w_len == 7'd0);
        if (w_accept) begin
            if (i_in.func == 1'b0) begin
                o_push       = 1'b1;
                n_in_frame   = (w_len != 7'd0);
                n_bytes_left = w_len;
            end else if (r_in_frame) begin
                o_push       = 1'b1;
                o_entry.kind = mfp_pkg::K_DATA;
                o_entry.b0   = i_in.data_byte;
                o_entry.last = (r_bytes_left <= 7'd1);
                n_bytes_left = (r_bytes_left != 7'd0) ? r_bytes_left - 7'd1 : 7'd0;
                n_in_frame   = (r_bytes_left > 7'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_bytes_left <= 7'd0;
        end else begin
            r_in_frame   <= n_in_frame;
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule

// ===== hw/rtl/mfp_queue.sv =====
// ----------------------------------------------------------------------------
// mfp_queue
// Short FIFO of entries between the front and the back.
// ----------------------------------------------------------------------------
module mfp_queue #(
    parameter int DEPTH = mfp_pkg::Q_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mfp_pkg::t_entry     i_entry,
    input  logic                i_pop,
    output mfp_pkg::t_entry     o_head,
    output mfp_pkg::t_q_stat    o_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mfp_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push;
    logic            w_pop;

    assign o_stat.empty = (r_count == CW'(0));
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/mfp_back.sv =====
// ----------------------------------------------------------------------------
// mfp_back
// Expands queued entries into frame bytes, folds each into the CRC and
// appends the CRC byte at frame end.
// ----------------------------------------------------------------------------
module mfp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mfp_pkg::t_entry     i_head,
    input  logic                i_q_empty,
    input  logic [7:0]          i_crc_poly,
    output logic                o_pop,
    mfp_out_if.source           o_out
);

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_end;
    logic [1:0] r_step;
    logic [7:0] r_crc;

    logic       w_adv;
    logic       w_take;
    logic       w_is_crc;
    logic       w_done;
    logic [7:0] w_byte;
    logic [7:0] w_crc_base;

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.frame_end = r_out_end;

    assign w_adv  = !r_out_valid || o_out.ready;
    assign w_take = w_adv && !i_q_empty;
    assign o_pop  = w_take && w_done;

    always_comb begin
        w_is_crc   = 1'b0;
        w_done     = 1'b0;
        w_byte     = i_head.b0;
        w_crc_base = r_crc;
        case (i_head.kind)
            mfp_pkg::K_START: begin
                case (r_step)
                    2'd0: begin
                        w_byte     = i_head.b0;
                        w_crc_base = 8'd0;
                    end
                    2'd1: w_byte = i_head.b1;
                    2'd2: begin
                        w_byte = i_head.b2;
                        w_done = !i_head.last;
                    end
                    default: begin
                        w_byte   = r_crc;
                        w_is_crc = 1'b1;
                        w_done   = 1'b1;
                    end
                endcase
            end
            default: begin
                if (r_step == 2'd0) begin
                    w_byte = i_head.b0;
                    w_done = !i_head.last;
                end else begin
                    w_byte   = r_crc;
                    w_is_crc = 1'b1;
                    w_done   = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= 2'd0;
            r_crc       <= 8'd0;
        end else begin
            if (w_adv) begin
                r_out_valid <= !i_q_empty;
            end
            if (w_take) begin
                r_step <= w_done ? 2'd0 : r_step + 2'd1;
                if (!w_is_crc) begin
                    r_crc <= mfp_pkg::crc8_absorb(w_crc_base, w_byte, i_crc_poly);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_byte <= w_byte;
            r_out_end  <= w_is_crc;
        end
    end

endmodule

// ===== hw/rtl/message_frame_packer_crc8_top.sv =====
// ----------------------------------------------------------------------------
// message_frame_packer_crc8_top
// Packs start and payload items into an addressed byte stream closed by a
// CRC-8 byte.
// ----------------------------------------------------------------------------
// An input item is taken every cycle while the four-entry queue between the
// front and the back has room. Output runs at one byte per cycle while the
// port is ready: a start gives three header bytes (four with a CRC when its
// length is zero), a payload byte gives one (two on the last byte of a
// frame), so the output port sets the sustained item rate; the queue absorbs
// bursts and the registered output stage lets input flow on while a byte
// waits. The back folds one byte per cycle into the CRC with the polynomial
// currently programmed. Registers: 0x0 device address, 0x4 CRC polynomial.
module message_frame_packer_crc8_top #(
    parameter int MAX_PAYLOAD = mfp_pkg::MAX_PAYLOAD_DEF,
    parameter int Q_DEPTH     = mfp_pkg::Q_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    mfp_in_if.sink                      i_in,
    mfp_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mfp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [7:0]       r_dev_addr;
    logic [7:0]       r_crc_poly;
    logic             w_wr;
    logic             w_push;
    logic             w_pop;
    mfp_pkg::t_entry  w_entry;
    mfp_pkg::t_entry  w_head;
    mfp_pkg::t_q_stat w_q_stat;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        if (paddr[2] == mfp_pkg::REG_CRC_POLY) begin
            prdata = {24'd0, r_crc_poly};
        end else begin
            prdata = {24'd0, r_dev_addr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= 8'd0;
            r_crc_poly <= 8'h07;
        end else if (w_wr) begin
            if (paddr[2] == mfp_pkg::REG_DEV_ADDR) begin
                r_dev_addr <= pwdata[7:0];
            end else begin
                r_crc_poly <= pwdata[7:0];
            end
        end
    end

    mfp_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_dev_addr (r_dev_addr),
        .i_q_full   (w_q_stat.full),
        .o_push     (w_push),
        .o_entry    (w_entry)
    );

    mfp_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    mfp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_empty  (w_q_stat.empty),
        .i_crc_poly (r_crc_poly),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

`ifndef SYNTHESIS
    a_start_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !i_in.func) |-> w_push)
        else $error("start item accepted without a queue entry");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from an empty queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("push into a full queue");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid straight after reset");
`endif

endmodule
